// ===== sv/fpmmu_pkg.sv =====
// Shared types, constants and helper functions for the flash page mapping table.
// Used by fpmmu_regs and flash_page_mmu_table_core; depends on nothing.
package fpmmu_pkg;

    localparam int ENTRIES = 512;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PIDX_W  = 12;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [31:0] ENTRIES_W32 = 32'(ENTRIES);

    // Commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_XLATE = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_BASE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAGE_SHIFT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PHYS_MASK   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INV_MASK    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PSRAM_MASK  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FLASH_DSIZE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FLASH_ISIZE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PSRAM_SIZE  = 3'd7;

    // Reset values
    localparam logic [31:0] RST_ENTRY_BASE  = 32'd0;
    localparam logic [4:0]  RST_PAGE_SHIFT  = 5'd16;
    localparam logic [31:0] RST_PHYS_MASK   = 32'd255;
    localparam logic [31:0] RST_INV_MASK    = 32'd256;
    localparam logic [31:0] RST_PSRAM_MASK  = 32'd32768;
    localparam logic [31:0] RST_FLASH_DSIZE = 32'd4194304;
    localparam logic [31:0] RST_FLASH_ISIZE = 32'd4194304;
    localparam logic [31:0] RST_PSRAM_SIZE  = 32'd0;

    localparam logic [4:0] SHIFT_MIN = 5'd12;
    localparam logic [4:0] SHIFT_MAX = 5'd24;

    typedef struct packed {
        logic [31:0] entry_base;
        logic [4:0]  page_shift;
        logic [31:0] phys_page_mask;
        logic [31:0] invalid_bit_mask;
        logic [31:0] psram_bit_mask;
        logic [31:0] flash_data_size;
        logic [31:0] flash_insn_size;
        logic [31:0] psram_size;
    } cfg_t;

    function automatic logic [4:0] eff_shift(input logic [4:0] sh);
        logic [4:0] r;
        r = sh;
        if (sh < SHIFT_MIN) r = SHIFT_MIN;
        if (sh > SHIFT_MAX) r = SHIFT_MAX;
        return r;
    endfunction

    // Whole page [base, base + psize) lies inside [0, size)
    function automatic logic fits(input logic [31:0] base, input logic [31:0] psize,
                                  input logic [31:0] size);
        return (base <= size) && (psize <= (size - base));
    endfunction

endpackage

// ===== sv/fpmmu_regs.sv =====
// APB-style configuration register file of the flash page mapping table.
// Depends on fpmmu_pkg for the register map, reset values and cfg_t.
module fpmmu_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fpmmu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output fpmmu_pkg::cfg_t                   cfg
);

    fpmmu_pkg::cfg_t                    cfg_reg;
    logic [fpmmu_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                               wr_en;

    assign reg_idx = paddr[fpmmu_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.entry_base       <= fpmmu_pkg::RST_ENTRY_BASE;
            cfg_reg.page_shift       <= fpmmu_pkg::RST_PAGE_SHIFT;
            cfg_reg.phys_page_mask   <= fpmmu_pkg::RST_PHYS_MASK;
            cfg_reg.invalid_bit_mask <= fpmmu_pkg::RST_INV_MASK;
            cfg_reg.psram_bit_mask   <= fpmmu_pkg::RST_PSRAM_MASK;
            cfg_reg.flash_data_size  <= fpmmu_pkg::RST_FLASH_DSIZE;
            cfg_reg.flash_insn_size  <= fpmmu_pkg::RST_FLASH_ISIZE;
            cfg_reg.psram_size       <= fpmmu_pkg::RST_PSRAM_SIZE;
        end else if (wr_en) begin
            unique case (reg_idx)
                fpmmu_pkg::REG_ENTRY_BASE:  cfg_reg.entry_base       <= pwdata;
                fpmmu_pkg::REG_PAGE_SHIFT:  cfg_reg.page_shift       <= pwdata[4:0];
                fpmmu_pkg::REG_PHYS_MASK:   cfg_reg.phys_page_mask   <= pwdata;
                fpmmu_pkg::REG_INV_MASK:    cfg_reg.invalid_bit_mask <= pwdata;
                fpmmu_pkg::REG_PSRAM_MASK:  cfg_reg.psram_bit_mask   <= pwdata;
                fpmmu_pkg::REG_FLASH_DSIZE: cfg_reg.flash_data_size  <= pwdata;
                fpmmu_pkg::REG_FLASH_ISIZE: cfg_reg.flash_insn_size  <= pwdata;
                fpmmu_pkg::REG_PSRAM_SIZE:  cfg_reg.psram_size       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fpmmu_pkg::REG_ENTRY_BASE:  prdata = cfg_reg.entry_base;
            fpmmu_pkg::REG_PAGE_SHIFT:  prdata = 32'(cfg_reg.page_shift);
            fpmmu_pkg::REG_PHYS_MASK:   prdata = cfg_reg.phys_page_mask;
            fpmmu_pkg::REG_INV_MASK:    prdata = cfg_reg.invalid_bit_mask;
            fpmmu_pkg::REG_PSRAM_MASK:  prdata = cfg_reg.psram_bit_mask;
            fpmmu_pkg::REG_FLASH_DSIZE: prdata = cfg_reg.flash_data_size;
            fpmmu_pkg::REG_FLASH_ISIZE: prdata = cfg_reg.flash_insn_size;
            fpmmu_pkg::REG_PSRAM_SIZE:  prdata = cfg_reg.psram_size;
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/flash_page_mmu_table_core.sv =====
// A request accepted in S_IDLE passes S_DEC and S_MAP and loads the result register in S_DONE.
// Requests are taken one at a time, each walking four states (accept, decode +
// table read, modify + write back, mapping check); S_DONE stalls while a result waits.
// Reset: synchronous active-low; afterwards a clearing pass over all ENTRIES (512) table words
// fills the table with invalid entries while s_ready stays low; APB writes still land.
module flash_page_mmu_table_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [31:0]                       s_bus_address,
    input  logic [31:0]                       s_write_data,
    input  logic [31:0]                       s_window_offset,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [31:0]                       m_read_data,
    output logic                              m_entry_changed,
    output logic [fpmmu_pkg::PIDX_W-1:0]      m_page_index,
    output logic                              m_mapped,
    output logic                              m_backing,
    output logic [31:0]                       m_physical_address,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fpmmu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int IDX_W = fpmmu_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_CLEAR,    // sweep the table to invalid entries after reset
        S_IDLE,     // wait for a request
        S_DEC,      // decode address / page, read the table
        S_MAP,      // merge write data, write back, form page base
        S_DONE      // check bounds, load the result register
    } state_t;

    fpmmu_pkg::cfg_t cfg;

    fpmmu_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Page table memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [31:0]      mem [fpmmu_pkg::ENTRIES];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [31:0]      mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Control and pipeline registers
    // ------------------------------------------------------------------
    state_t           state_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    // captured request
    logic [1:0]       cmd_reg;
    logic [31:0]      addr_reg;
    logic [31:0]      wdata_reg;
    logic [31:0]      woff_reg;

    // decode results
    logic             ok_reg;       // table access aligned and in range
    logic             hit_reg;      // translate page inside the table
    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      within_reg;
    logic [4:0]       sh_reg;

    // modify results
    logic [31:0]      val_reg;
    logic             chg_reg;
    logic [31:0]      base_reg;
    logic             inv_reg;
    logic             psram_reg;
    logic [31:0]      dsize_reg;
    logic [31:0]      isize_reg;

    // result register
    logic             m_valid_reg;
    logic [31:0]      rd_reg;
    logic             chg_out_reg;
    logic [fpmmu_pkg::PIDX_W-1:0] pidx_reg;
    logic             mapped_reg;
    logic             back_reg;
    logic [31:0]      phys_reg;

    // ------------------------------------------------------------------
    // Decode: table offset and window page
    // ------------------------------------------------------------------
    logic [4:0]       sh_next;
    logic [31:0]      offset_next;
    logic             ok_next;
    logic [31:0]      page_next;
    logic             hit_next;
    logic [IDX_W-1:0] idx_next;
    logic [31:0]      within_next;

    always_comb begin
        sh_next     = fpmmu_pkg::eff_shift(cfg.page_shift);
        offset_next = addr_reg - cfg.entry_base;
        ok_next     = (offset_next[1:0] == 2'b00) &&
                      ((offset_next >> 2) < fpmmu_pkg::ENTRIES_W32);
        page_next   = woff_reg >> sh_next;
        hit_next    = page_next < fpmmu_pkg::ENTRIES_W32;
        within_next = woff_reg & ((32'd1 << sh_next) - 32'd1);
        if (cmd_reg == fpmmu_pkg::CMD_XLATE) begin
            idx_next = page_next[IDX_W-1:0];
        end else begin
            idx_next = offset_next[IDX_W+1:2];
        end
    end

    assign mem_raddr = idx_next;

    // ------------------------------------------------------------------
    // Modify: merge write data, derive page base and backing
    // ------------------------------------------------------------------
    logic        is_write;
    logic [31:0] val_next;
    logic        psram_next;

    assign is_write = (cmd_reg == fpmmu_pkg::CMD_WRITE);

    always_comb begin
        if (is_write) begin
            val_next = wdata_reg & (cfg.phys_page_mask | cfg.invalid_bit_mask |
                                    cfg.psram_bit_mask);
        end else begin
            val_next = mem_rdata_reg;
        end
        psram_next = (cfg.psram_bit_mask != 32'd0) &&
                     ((val_next & cfg.psram_bit_mask) != 32'd0);
    end

    // Table write port: clearing sweep or accepted write in the modify step
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = val_next;
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = fpmmu_pkg::RST_INV_MASK;
        end else if (state_reg == S_MAP && is_write && ok_reg) begin
            mem_we = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Check: page must fit both window sizes of its backing store
    // ------------------------------------------------------------------
    logic [31:0] psize_next;
    logic        mapped_next;
    logic        load_out;

    assign psize_next  = 32'd1 << sh_reg;
    assign mapped_next = !inv_reg &&
                         fpmmu_pkg::fits(base_reg, psize_next, dsize_reg) &&
                         fpmmu_pkg::fits(base_reg, psize_next, isize_reg);
    assign load_out    = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // result register: hold until taken
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
                    if (clr_cnt_reg == IDX_W'(fpmmu_pkg::ENTRIES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= s_command;
                        addr_reg  <= s_bus_address;
                        wdata_reg <= s_write_data;
                        woff_reg  <= s_window_offset;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    ok_reg     <= ok_next;
                    hit_reg    <= hit_next;
                    idx_reg    <= idx_next;
                    within_reg <= within_next;
                    sh_reg     <= sh_next;
                    state_reg  <= S_MAP;
                end
                S_MAP: begin
                    val_reg   <= val_next;
                    chg_reg   <= (mem_rdata_reg != val_next);
                    base_reg  <= (val_next & cfg.phys_page_mask) << sh_reg;
                    inv_reg   <= (val_next & cfg.invalid_bit_mask) != 32'd0;
                    psram_reg <= psram_next;
                    dsize_reg <= psram_next ? cfg.psram_size : cfg.flash_data_size;
                    isize_reg <= psram_next ? cfg.psram_size : cfg.flash_insn_size;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // stall here while the previous result is still waiting
                    if (load_out) begin
                        rd_reg      <= 32'd0;
                        chg_out_reg <= 1'b0;
                        pidx_reg    <= '0;
                        mapped_reg  <= 1'b0;
                        back_reg    <= 1'b0;
                        phys_reg    <= 32'd0;
                        unique case (cmd_reg)
                            fpmmu_pkg::CMD_READ: begin
                                if (ok_reg) begin
                                    rd_reg <= val_reg;
                                end
                            end
                            fpmmu_pkg::CMD_WRITE: begin
                                if (ok_reg) begin
                                    rd_reg      <= val_reg;
                                    chg_out_reg <= chg_reg;
                                    pidx_reg    <= fpmmu_pkg::PIDX_W'(idx_reg);
                                    mapped_reg  <= mapped_next;
                                    back_reg    <= psram_reg;
                                    phys_reg    <= base_reg;
                                end
                            end
                            fpmmu_pkg::CMD_XLATE: begin
                                if (hit_reg) begin
                                    rd_reg     <= val_reg;
                                    pidx_reg   <= fpmmu_pkg::PIDX_W'(idx_reg);
                                    mapped_reg <= mapped_next;
                                    back_reg   <= psram_reg;
                                    phys_reg   <= base_reg + within_reg;
                                end
                            end
                            default: ;  // unused command: all-zero result
                        endcase
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_read_data        = rd_reg;
    assign m_entry_changed    = chg_out_reg;
    assign m_page_index       = pidx_reg;
    assign m_mapped           = mapped_reg;
    assign m_backing          = back_reg;
    assign m_physical_address = phys_reg;

`ifndef NO_ASSERTIONS
    // Table is written only by the clearing sweep or an accepted write
    a_mem_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_CLEAR) ||
                   (state_reg == S_MAP && is_write && ok_reg))
        else $error("page table written outside sweep or accepted write");

    // A mapped page never carries an invalid bit
    a_mapped_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_mapped) |-> ((m_read_data & cfg.invalid_bit_mask) == 32'd0))
        else $error("result reports mapped page with invalid bit set");

    // A finished request waits while the result register is still occupied
    a_done_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid && !m_ready) |=> (state_reg == S_DONE))
        else $error("result register overwritten before it was taken");

    // No request is taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("request accepted during table clear");
`endif

endmodule
